/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a rising clk edge.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* rtl/ubx_pkg.sv */
// Types and constants shared by the UBX frame parser modules.
package ubx_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [7:0] CLASS_RESET = 8'h01;
    localparam logic [7:0] ID_RESET    = 8'h3C;
    localparam logic [7:0] LIMIT_RESET = 8'd64;

    // configuration register indexes
    localparam logic [1:0] REG_CLASS = 2'd0;
    localparam logic [1:0] REG_ID    = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;

    typedef struct packed {
        logic [7:0] expected_class;
        logic [7:0] expected_id;
        logic [7:0] capture_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
    } res_t;

endpackage

/* rtl/ubx_parse_core.sv */
// Byte-serial UBX frame state machine with Fletcher-8 checksum.
`include "assert_macros.svh"

module ubx_parse_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [7:0]    rx_byte,
    input  ubx_pkg::cfg_t cfg,
    output logic          res_valid,
    output ubx_pkg::res_t res
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_GOT_SYNC1 = 4'd1;
    localparam logic [3:0] ST_GOT_SYNC2 = 4'd2;
    localparam logic [3:0] ST_GOT_CLASS = 4'd3;
    localparam logic [3:0] ST_LEN_LOW   = 4'd4;
    localparam logic [3:0] ST_LEN_HIGH  = 4'd5;
    localparam logic [3:0] ST_PAYLOAD   = 4'd6;
    localparam logic [3:0] ST_CHECK_A   = 4'd7;
    localparam logic [3:0] ST_CHECK_B   = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  write_pos_reg, write_pos_next;
    logic [7:0]  sum_a_add;
    logic [7:0]  sum_b_add;
    logic [15:0] left_dec;

    assign sum_a_add = sum_a_reg + rx_byte;
    assign sum_b_add = sum_b_reg + sum_a_add;
    assign left_dec  = bytes_left_reg - 16'd1;

    always_comb
    begin
        state_next      = state_reg;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        bytes_left_next = bytes_left_reg;
        write_pos_next  = write_pos_reg;
        res_valid       = 1'b0;
        res.kind         = ubx_pkg::KIND_PAYLOAD;
        res.payload_byte = 8'd0;
        res.byte_index   = 8'd0;
        if (in_valid)
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    state_next = (rx_byte == ubx_pkg::SYNC_FIRST) ? ST_GOT_SYNC1 : ST_IDLE;
                end
                ST_GOT_SYNC1:
                begin
                    state_next = (rx_byte == ubx_pkg::SYNC_SECOND) ? ST_GOT_SYNC2 : ST_IDLE;
                end
                ST_GOT_SYNC2:
                begin
                    if (rx_byte == cfg.expected_class)
                    begin
                        sum_a_next = rx_byte;
                        sum_b_next = rx_byte;
                        state_next = ST_GOT_CLASS;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_GOT_CLASS:
                begin
                    if (rx_byte == cfg.expected_id)
                    begin
                        sum_a_next = sum_a_add;
                        sum_b_next = sum_b_add;
                        state_next = ST_LEN_LOW;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_LEN_LOW:
                begin
                    bytes_left_next = {8'd0, rx_byte};
                    sum_a_next      = sum_a_add;
                    sum_b_next      = sum_b_add;
                    state_next      = ST_LEN_HIGH;
                end
                ST_LEN_HIGH:
                begin
                    bytes_left_next = {rx_byte, bytes_left_reg[7:0]};
                    sum_a_next      = sum_a_add;
                    sum_b_next      = sum_b_add;
                    write_pos_next  = 8'd0;
                    // empty payload skips straight to the checksum
                    state_next = ({rx_byte, bytes_left_reg[7:0]} == 16'd0) ?
                                 ST_CHECK_A : ST_PAYLOAD;
                end
                ST_PAYLOAD:
                begin
                    if (write_pos_reg < cfg.capture_limit)
                    begin
                        res_valid        = 1'b1;
                        res.kind         = ubx_pkg::KIND_PAYLOAD;
                        res.payload_byte = rx_byte;
                        res.byte_index   = write_pos_reg;
                        write_pos_next   = write_pos_reg + 8'd1;
                    end
                    sum_a_next      = sum_a_add;
                    sum_b_next      = sum_b_add;
                    bytes_left_next = left_dec;
                    if (left_dec == 16'd0)
                    begin
                        state_next = ST_CHECK_A;
                    end
                end
                ST_CHECK_A:
                begin
                    if (rx_byte == sum_a_reg)
                    begin
                        state_next = ST_CHECK_B;
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        res.kind   = ubx_pkg::KIND_BAD;
                        state_next = ST_IDLE;
                    end
                end
                ST_CHECK_B:
                begin
                    res_valid  = 1'b1;
                    res.kind   = (rx_byte == sum_b_reg) ? ubx_pkg::KIND_GOOD
                                                        : ubx_pkg::KIND_BAD;
                    state_next = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sum_a_reg      <= 8'd0;
            sum_b_reg      <= 8'd0;
            bytes_left_reg <= 16'd0;
            write_pos_reg  <= 8'd0;
        end
        else
        begin
            state_reg      <= state_next;
            sum_a_reg      <= sum_a_next;
            sum_b_reg      <= sum_b_next;
            bytes_left_reg <= bytes_left_next;
            write_pos_reg  <= write_pos_next;
        end
    end

    `ASSERT_CLK(a_good_only_on_chk_b,
        res_valid && res.kind == ubx_pkg::KIND_GOOD |-> state_reg == ST_CHECK_B,
        "good report outside second checksum byte")
    `ASSERT_CLK(a_payload_in_limit,
        res_valid && res.kind == ubx_pkg::KIND_PAYLOAD |->
            state_reg == ST_PAYLOAD && write_pos_reg < cfg.capture_limit,
        "payload beat outside capture window")
    `ASSERT_CLK(a_len_high_exit,
        in_valid && state_reg == ST_LEN_HIGH |=>
            state_reg == ST_PAYLOAD || state_reg == ST_CHECK_A,
        "bad exit from length high byte")

endmodule

/* rtl/ubx_out_skid.sv */
// Output register plus skid stage for the result stream.
`include "assert_macros.svh"

module ubx_out_skid (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  ubx_pkg::res_t in_data,
    output logic          in_ready,
    output logic          out_valid,
    output ubx_pkg::res_t out_data,
    input  logic          out_ready
);

    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    ubx_pkg::res_t out_data_reg, out_data_next;
    ubx_pkg::res_t skid_data_reg, skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end
        else if (in_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `ASSERT_CLK(a_skid_behind_out, skid_valid_reg |-> out_valid_reg,
        "skid stage full while output register empty")
    `ASSERT_CLK(a_skid_drains, skid_valid_reg && out_ready |=> out_valid_reg && !skid_valid_reg,
        "skid stage did not drain into output register")
    `ASSERT_NEVER(a_no_overrun, in_valid && skid_valid_reg,
        "result arrived while skid stage full")

endmodule

/* rtl/ubx_frame_parser_top.sv */
// Top level of the UBX frame parser: config registers, parser core, output buffer.
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       s_tdata[7:0] rx_byte
//  m_*       out  m_tvalid / m_tready       m_tdata payload_byte, byte_index; m_tuser kind
//  cfg_*     in   cfg_valid / cfg_ready     cfg_index register, cfg_data value
//
// One beat per cycle while s_tready is high: each received byte updates the parser
// state in the cycle it is accepted, and any result is registered by the output stage.
// Results go through an output register and a one-deep skid stage, so s_tready
// drops only when both hold results that m_tready has not taken.
// rst_n clears the parser to hunting for sync and loads the register defaults
// (class 0x01, id 0x3C, capture limit 64). Config writes are always taken.
module ubx_frame_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    // receive byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] payload_byte, [15:8] byte_index
    output logic [1:0]  m_tuser,   // [1:0] kind
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    ubx_pkg::cfg_t cfg_reg;
    ubx_pkg::res_t core_res;
    ubx_pkg::res_t out_res;
    logic          core_res_valid;
    logic          in_beat;

    assign cfg_ready = 1'b1;
    assign in_beat   = s_tvalid && s_tready;

    // register file; unused index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_class <= ubx_pkg::CLASS_RESET;
            cfg_reg.expected_id    <= ubx_pkg::ID_RESET;
            cfg_reg.capture_limit  <= ubx_pkg::LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ubx_pkg::REG_CLASS: cfg_reg.expected_class <= cfg_data;
                ubx_pkg::REG_ID:    cfg_reg.expected_id    <= cfg_data;
                ubx_pkg::REG_LIMIT: cfg_reg.capture_limit  <= cfg_data;
                default:            ;
            endcase
        end
    end

    ubx_parse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_beat),
        .rx_byte   (s_tdata),
        .cfg       (cfg_reg),
        .res_valid (core_res_valid),
        .res       (core_res)
    );

    ubx_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (core_res_valid),
        .in_data   (core_res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {out_res.byte_index, out_res.payload_byte};
    assign m_tuser = out_res.kind;

endmodule

/* tb/sv/ubx_frame_check_pkg.sv */
// Frame tracker class: predicts UBX parser results and checks them beat by beat.
`timescale 1ns / 100ps
package ubx_frame_check_pkg;
    import ubx_pkg::*;

    typedef enum logic [3:0] {
        PS_IDLE,
        PS_SYNC1,
        PS_SYNC2,
        PS_CLASS,
        PS_LEN_LO,
        PS_LEN_HI,
        PS_PAYLOAD,
        PS_CHECK_A,
        PS_CHECK_B
    } parse_phase_e;

    localparam int unsigned MAX_REPORTS = 40;

    class ubx_frame_tracker;
        cfg_t         regs;
        parse_phase_e phase;
        logic [7:0]   sum_a;
        logic [7:0]   sum_b;
        logic [15:0]  bytes_left;
        logic [7:0]   write_pos;
        res_t         pending_results[$];
        int unsigned  errors;
        int unsigned  rx_bytes;
        int unsigned  results_checked;
        int unsigned  payload_hits;
        int unsigned  good_frames;
        int unsigned  bad_frames;
        int unsigned  reg_writes;

        function new();
            regs.expected_class = CLASS_RESET;
            regs.expected_id    = ID_RESET;
            regs.capture_limit  = LIMIT_RESET;
            phase           = PS_IDLE;
            sum_a           = '0;
            sum_b           = '0;
            bytes_left      = '0;
            write_pos       = '0;
            errors          = 0;
            rx_bytes        = 0;
            results_checked = 0;
            payload_hits    = 0;
            good_frames     = 0;
            bad_frames      = 0;
            reg_writes      = 0;
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [7:0] val);
            reg_writes++;
            case (idx)
                REG_CLASS: regs.expected_class = val;
                REG_ID:    regs.expected_id    = val;
                REG_LIMIT: regs.capture_limit  = val;
                default:   ;
            endcase
        endfunction

        // Fletcher-8 running sums
        function void add_sum(input logic [7:0] b);
            sum_a = sum_a + b;
            sum_b = sum_b + sum_a;
        endfunction

        function void expect_result(input logic [1:0] kind, input logic [7:0] value,
                                    input logic [7:0] index);
            res_t r;
            r.kind         = kind;
            r.payload_byte = value;
            r.byte_index   = index;
            pending_results.push_back(r);
        endfunction

        // one accepted rx byte: advance the parser copy, queue any result
        function void take_rx_byte(input logic [7:0] b);
            rx_bytes++;
            case (phase)
                PS_IDLE:  phase = (b == SYNC_FIRST) ? PS_SYNC1 : PS_IDLE;
                PS_SYNC1: phase = (b == SYNC_SECOND) ? PS_SYNC2 : PS_IDLE;
                PS_SYNC2:
                    if (b == regs.expected_class)
                    begin
                        sum_a = b;
                        sum_b = b;
                        phase = PS_CLASS;
                    end
                    else
                        phase = PS_IDLE;
                PS_CLASS:
                    if (b == regs.expected_id)
                    begin
                        add_sum(b);
                        phase = PS_LEN_LO;
                    end
                    else
                        phase = PS_IDLE;
                PS_LEN_LO:
                begin
                    bytes_left = {8'h00, b};
                    add_sum(b);
                    phase = PS_LEN_HI;
                end
                PS_LEN_HI:
                begin
                    bytes_left[15:8] = b;
                    add_sum(b);
                    write_pos = '0;
                    phase = (bytes_left == 16'd0) ? PS_CHECK_A : PS_PAYLOAD;
                end
                PS_PAYLOAD:
                begin
                    if (write_pos < regs.capture_limit)
                    begin
                        expect_result(KIND_PAYLOAD, b, write_pos);
                        payload_hits++;
                        write_pos++;
                    end
                    add_sum(b);
                    bytes_left--;
                    if (bytes_left == 16'd0)
                        phase = PS_CHECK_A;
                end
                PS_CHECK_A:
                    if (b == sum_a)
                        phase = PS_CHECK_B;
                    else
                    begin
                        expect_result(KIND_BAD, 8'h00, 8'h00);
                        bad_frames++;
                        phase = PS_IDLE;
                    end
                PS_CHECK_B:
                begin
                    if (b == sum_b)
                    begin
                        expect_result(KIND_GOOD, 8'h00, 8'h00);
                        good_frames++;
                    end
                    else
                    begin
                        expect_result(KIND_BAD, 8'h00, 8'h00);
                        bad_frames++;
                    end
                    phase = PS_IDLE;
                end
                default: phase = PS_IDLE;
            endcase
        endfunction

        task report_mismatch(input string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        // one accepted result beat against the oldest prediction
        task match_result(input logic [1:0] kind, input logic [15:0] data);
            res_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result kind %0d data 0x%04h with none pending",
                                          kind, data));
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
            if (data[7:0] !== want.payload_byte)
                report_mismatch($sformatf("payload_byte 0x%02h, want 0x%02h",
                                          data[7:0], want.payload_byte));
            if (data[15:8] !== want.byte_index)
                report_mismatch($sformatf("byte_index %0d, want %0d",
                                          data[15:8], want.byte_index));
        endtask
    endclass

endpackage

/* tb/sv/tb_ubx_frame_parser_top.sv */
// Testbench top for the UBX frame parser: random frame traffic, stalls and config phases.
`timescale 1ns / 100ps
module tb_ubx_frame_parser_top;

    // run limits, in clock cycles
    localparam int unsigned WATCHDOG_LIMIT = 3000;  // cycles with no beat on any channel
    localparam int unsigned LONG_STALL     = 400;   // one long receiver hold-off
    localparam int unsigned SETTLE_CYCLES  = 8;     // output register + skid stage, with margin
    localparam int unsigned END_CYCLES     = 20;

    // frame defects the stimulus can inject
    typedef enum {
        FLAW_NONE,
        FLAW_CK_A,    // first checksum byte wrong
        FLAW_CK_B,    // second checksum byte wrong
        FLAW_CLASS,   // foreign class
        FLAW_ID,      // foreign id
        FLAW_SYNC,    // broken sync pair
        FLAW_TRUNC,   // payload cut short, no checksum
        FLAW_NOISE    // a few random bytes, no frame
    } flaw_t;

    // receiver stall styles
    typedef enum {
        RX_ALWAYS,
        RX_COIN,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    ubx_frame_check_pkg::ubx_frame_tracker trk = new();

    // stimulus state shared by the tasks below
    logic [7:0]  tx_q[$];
    logic [7:0]  cur_class;
    logic [7:0]  cur_id;
    bit          stall_request = 1'b0;
    int unsigned long_stalls = 0;
    int unsigned settings_used = 1;   // reset defaults count as the first

    ubx_frame_parser_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Beat monitor. All TB inputs change by NBA, so at the edge these reads
    // see the pre-edge values the DUT itself sampled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                trk.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                trk.take_rx_byte(s_tdata);
            if (m_tvalid && m_tready)
                trk.match_result(m_tuser, m_tdata);
        end
    end

    // Watchdog: any beat on any channel restarts the count.
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] watchdog: no beat for %0d cycles, %0d results still pending",
                 $time, WATCHDOG_LIMIT, trk.pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random-length segments, each with its own stall style. A
    // request from the main flow puts a long hold-off before the next segment
    // so the output buffer fills and s_tready drops.
    initial
    begin
        int unsigned seg;
        int unsigned tick;
        rx_mode_t    mode;
        m_tready <= 1'b0;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            if (stall_request)
            begin
                stall_request = 1'b0;
                long_stalls++;
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end
            mode = rx_mode_t'($urandom_range(0, 3));
            seg  = $urandom_range(1, 60);
            repeat (seg)
            begin
                case (mode)
                    RX_ALWAYS:  m_tready <= 1'b1;
                    RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: m_tready <= ((tick % 5) < 3);
                    RX_SPARSE:  m_tready <= ($urandom_range(0, 7) == 0);
                    default:    m_tready <= 1'b1;
                endcase
                tick++;
                @(posedge clk);
            end
        end
    end

    // Queue one frame (or a defect variant) with a correct Fletcher-8 trailer
    // unless the defect says otherwise.
    function automatic void push_frame(input logic [7:0] cls, input logic [7:0] id,
                                       input int unsigned len, input flaw_t flaw);
        logic [7:0]  body[$];
        logic [7:0]  ck_a;
        logic [7:0]  ck_b;
        logic [7:0]  fb;
        int unsigned n_pay;
        if (flaw == FLAW_NOISE)
        begin
            repeat ($urandom_range(1, 8)) tx_q.push_back(8'($urandom));
            return;
        end
        ck_a  = '0;
        ck_b  = '0;
        n_pay = (flaw == FLAW_TRUNC) ? len / 2 : len;
        body.push_back((flaw == FLAW_CLASS) ? cls ^ 8'($urandom_range(1, 255)) : cls);
        body.push_back((flaw == FLAW_ID) ? id ^ 8'($urandom_range(1, 255)) : id);
        body.push_back(len[7:0]);
        body.push_back(len[15:8]);
        repeat (n_pay) body.push_back(8'($urandom));
        tx_q.push_back(ubx_pkg::SYNC_FIRST);
        if (flaw == FLAW_SYNC)
        begin
            // a bad second sync byte, then a real one that must not resync
            fb = $urandom_range(0, 1) ? ubx_pkg::SYNC_FIRST : 8'($urandom);
            tx_q.push_back((fb == ubx_pkg::SYNC_SECOND) ? 8'h00 : fb);
        end
        tx_q.push_back(ubx_pkg::SYNC_SECOND);
        foreach (body[i])
        begin
            ck_a = ck_a + body[i];
            ck_b = ck_b + ck_a;
            tx_q.push_back(body[i]);
        end
        if (flaw == FLAW_TRUNC)
            return;
        tx_q.push_back((flaw == FLAW_CK_A) ? ck_a ^ 8'($urandom_range(1, 255)) : ck_a);
        tx_q.push_back((flaw == FLAW_CK_B) ? ck_b ^ 8'($urandom_range(1, 255)) : ck_b);
    endfunction

    // Fill the byte queue up to target with a mix of clean and defective frames.
    function automatic void queue_random_frames(input int unsigned target,
                                                input int unsigned good_pct);
        int unsigned roll;
        int unsigned len;
        flaw_t       flaw;
        while (tx_q.size() < target)
        begin
            roll = $urandom_range(0, 99);
            // mostly short payloads, now and then one past a small capture limit
            len  = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 12);
            if (roll < good_pct)
                flaw = FLAW_NONE;
            else
                case (roll % 7)
                    0:       flaw = FLAW_CK_A;
                    1:       flaw = FLAW_CK_B;
                    2:       flaw = FLAW_CLASS;
                    3:       flaw = FLAW_ID;
                    4:       flaw = FLAW_SYNC;
                    5:       flaw = FLAW_TRUNC;
                    default: flaw = FLAW_NOISE;
                endcase
            push_frame(cur_class, cur_id, len, flaw);
        end
    endfunction

    // Send the queued bytes in bursts. With gaps on, each burst is followed
    // by a random idle stretch; s_tdata carries junk while tvalid is low.
    task automatic send_queued(input bit with_gaps);
        int unsigned burst;
        while (tx_q.size() > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && tx_q.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= tx_q.pop_front();
                do @(posedge clk); while (!s_tready);
                burst--;
            end
            if (with_gaps)
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom);
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        // with gaps on, tvalid is already low after the last idle stretch
        if (!with_gaps)
            s_tvalid <= 1'b0;
    endtask

    task automatic drive_reg_write(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Only called with the parser quiet: nothing pending and settle time spent.
    task automatic set_config(input logic [7:0] cls, input logic [7:0] id,
                              input logic [7:0] limit);
        drive_reg_write(ubx_pkg::REG_CLASS, cls);
        drive_reg_write(ubx_pkg::REG_ID, id);
        drive_reg_write(ubx_pkg::REG_LIMIT, limit);
        cfg_valid <= 1'b0;
        cur_class = cls;
        cur_id    = id;
        settings_used++;
    endtask

    // Wait until every predicted result has come out, then let the pipe settle.
    task automatic drain();
        do @(posedge clk); while (trk.pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_index <= ubx_pkg::REG_CLASS;
        cfg_data  <= 8'h00;
        cur_class = ubx_pkg::CLASS_RESET;
        cur_id    = ubx_pkg::ID_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset defaults: empty frame, lost sync, foreign class/id,
        // short frame with a bad first checksum byte
        push_frame(ubx_pkg::CLASS_RESET, ubx_pkg::ID_RESET, 0, FLAW_NONE);
        tx_q.push_back(ubx_pkg::SYNC_FIRST);
        tx_q.push_back(ubx_pkg::SYNC_FIRST);
        tx_q.push_back(ubx_pkg::SYNC_SECOND);
        tx_q.push_back(8'h00);
        tx_q.push_back(ubx_pkg::SYNC_FIRST);
        tx_q.push_back(ubx_pkg::SYNC_SECOND);
        tx_q.push_back(ubx_pkg::CLASS_RESET + 8'd1);
        tx_q.push_back(ubx_pkg::SYNC_FIRST);
        tx_q.push_back(ubx_pkg::SYNC_SECOND);
        tx_q.push_back(ubx_pkg::CLASS_RESET);
        tx_q.push_back(ubx_pkg::ID_RESET + 8'd1);
        push_frame(ubx_pkg::CLASS_RESET, ubx_pkg::ID_RESET, 2, FLAW_CK_A);
        send_queued(1'b1);

        queue_random_frames(280, 55);
        send_queued(1'b1);
        drain();

        // extremes: class all ones, id zero, nothing captured
        set_config(8'hFF, 8'h00, 8'd0);
        queue_random_frames(200, 55);
        send_queued(1'b1);
        drain();

        // other extremes: one frame long enough to hit byte_index 254, no gaps
        set_config(8'h00, 8'hFF, 8'd255);
        push_frame(cur_class, cur_id, 260, FLAW_NONE);
        queue_random_frames(415, 55);
        send_queued(1'b0);
        drain();

        // back-pressure: receiver holds off for a long stretch while bytes
        // keep coming, so the output stage fills and the input stalls
        set_config(8'($urandom), 8'($urandom), 8'd200);
        stall_request = 1'b1;
        queue_random_frames(250, 85);
        send_queued(1'b0);
        drain();

        repeat (2)
        begin
            set_config(8'($urandom), 8'($urandom),
                       $urandom_range(0, 1) ? 8'($urandom_range(1, 16)) : 8'($urandom));
            queue_random_frames(250, 55);
            send_queued(1'b1);
            drain();
        end

        repeat (END_CYCLES) @(posedge clk);
        if (trk.pending_results.size() != 0)
            trk.report_mismatch($sformatf("%0d results never arrived",
                                          trk.pending_results.size()));

        $display("Run covered %0d rx bytes under %0d register settings (%0d writes), %0d %s",
                 trk.rx_bytes, settings_used, trk.reg_writes, long_stalls,
                 "long hold-off(s)");
        $display("Checked %0d result beats: %0d payload bytes, %0d good and %0d bad %s",
                 trk.results_checked, trk.payload_hits, trk.good_frames, trk.bad_frames,
                 "frame reports");
        if (trk.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/ubx_pkg.sv
rtl/ubx_parse_core.sv
rtl/ubx_out_skid.sv
rtl/ubx_frame_parser_top.sv
tb/sv/ubx_frame_check_pkg.sv
tb/sv/tb_ubx_frame_parser_top.sv
